>>> hw/rtl/aes128_block_encrypt_core_defines.svh
// ----------------------------------------------------------------------------
// AES assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define AES_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// A value must not change in the cycle after the condition holds.
`define AES_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("assertion failed: value changed while stalled");

`endif

>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions for the round pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] RconFirst = 8'h01;
  localparam logic [7:0] GfPoly = 8'h1b;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW = 1'b1;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Multiplication by x in GF(2^8).
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // Byte i of a block; byte 0 is the most significant.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127 - 8 * i -: 8];
  endfunction

endpackage

>>> hw/rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One round of the cipher and of the key schedule, registered at the output.
// ----------------------------------------------------------------------------
module aes_round_cell import aes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       last_i,
  input  logic [7:0] rcon_i,
  input  logic       valid_i,
  input  block_t     state_i,
  input  block_t     key_i,
  output logic       valid_o,
  output block_t     state_o,
  output block_t     key_o
);

  logic   valid_q;
  block_t state_q, state_d;
  block_t key_q, key_d;

  // Next round key from the current one.
  always_comb begin
    logic [7:0] t [4];
    logic [7:0] k [16];
    for (int i = 0; i < 16; i++) begin
      k[i] = get_byte(key_i, i);
    end
    t[0] = sbox(k[13]) ^ rcon_i;
    t[1] = sbox(k[14]);
    t[2] = sbox(k[15]);
    t[3] = sbox(k[12]);
    for (int i = 0; i < 4; i++) begin
      k[i] = k[i] ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      k[i] = k[i] ^ k[i - 4];
    end
    for (int i = 0; i < 16; i++) begin
      key_d[127 - 8 * i -: 8] = k[i];
    end
  end

  // SubBytes, ShiftRows, MixColumns unless last, then AddRoundKey.
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4 * c + r] = sbox(get_byte(state_i, 4 * ((c + r) % 4) + r));
      end
    end
    if (!last_i) begin
      for (int c = 0; c < 4; c++) begin
        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
        s[4 * c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
        s[4 * c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
        s[4 * c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
        s[4 * c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_d[127 - 8 * i -: 8] = s[i];
    end
    state_d = state_d ^ key_d;
  end

  // Valid flag under reset; payload advances with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

>>> hw/rtl/aes128_block_encrypt_core.sv
// Each block passes through one input stage and then ten round cells.
// Throughput: one block per cycle unless the chain holds; the unrolled chain of ten round cells sets it.
// The whole chain advances together and holds while the output is stalled and full.
// Reset clears the valid flags and both key registers to zero.
// ----------------------------------------------------------------------------
// AES-128 block encryption core
// Ten-cell round pipeline with on-the-fly key expansion carried with each block.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plaintext_high_i,
  input  logic [63:0] plaintext_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] ciphertext_high_o,
  output logic [63:0] ciphertext_low_o
);

  logic [63:0] key_high_q, key_low_q;
  logic        valid_q;
  block_t      state_q, key_q;
  logic        en;

  logic   cell_valid [NumRounds + 1];
  block_t cell_state [NumRounds + 1];
  block_t cell_key   [NumRounds + 1];
  logic [7:0] rcon   [NumRounds];

  // Pipeline moves when the final stage is empty or being taken.
  assign en = !cell_valid[NumRounds] || !out_stall_i;
  assign in_stall_o = !en;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: initial AddRoundKey.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      state_q <= {plaintext_high_i, plaintext_low_i} ^ {key_high_q, key_low_q};
      key_q   <= {key_high_q, key_low_q};
    end
  end

  assign cell_valid[0] = valid_q;
  assign cell_state[0] = state_q;
  assign cell_key[0]   = key_q;

  // Round constants.
  always_comb begin
    rcon[0] = RconFirst;
    for (int i = 1; i < NumRounds; i++) begin
      rcon[i] = gf_double(rcon[i - 1]);
    end
  end

  // Chain of round cells.
  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .last_i  (g == NumRounds - 1),
      .rcon_i  (rcon[g]),
      .valid_i (cell_valid[g]),
      .state_i (cell_state[g]),
      .key_i   (cell_key[g]),
      .valid_o (cell_valid[g + 1]),
      .state_o (cell_state[g + 1]),
      .key_o   (cell_key[g + 1])
    );
  end

  assign out_valid_o       = cell_valid[NumRounds];
  assign ciphertext_high_o = cell_state[NumRounds][127:64];
  assign ciphertext_low_o  = cell_state[NumRounds][63:0];

endmodule

>>> hw/rtl/aes_checker.sv
// ----------------------------------------------------------------------------
// AES port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "aes128_block_encrypt_core_defines.svh"

module aes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] ciphertext_high_o,
  input logic [63:0] ciphertext_low_o
);

  // A stalled result holds.
  `AES_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `AES_ASSERT_HOLD(a_out_data_hi, clk_i, rst_ni, out_valid_o && out_stall_i, ciphertext_high_o)
  `AES_ASSERT_HOLD(a_out_data_lo, clk_i, rst_ni, out_valid_o && out_stall_i, ciphertext_low_o)
  // Input is stalled exactly when a result is waiting and stalled.
  `AES_ASSERT(a_stall, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i))

endmodule

bind aes128_block_encrypt_core aes_checker u_aes_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .ciphertext_high_o (ciphertext_high_o),
  .ciphertext_low_o  (ciphertext_low_o)
);
